@@ src/hps_pkg.sv @@
// ============================================================================
// hps_pkg: shared types and constants for the heading PD steering block
// Field widths, register codes, CORDIC arctangent table and stage structs.
// ============================================================================
package hps_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int COORD_W = 16;
  localparam int GAIN_W  = 16;
  localparam int DB_W    = 15;
  localparam int MAXC_W  = 17;
  localparam int AMT_W   = 17;
  localparam int DIR_W   = 2;
  localparam int ERR_W   = 16;
  localparam int IDX_W   = 4;
  localparam int CFG_W   = 17;

  // CORDIC datapath: coordinates scaled by 256, angle in 1/65536 degree
  localparam int XY_W  = 28;
  localparam int Z_W   = 27;
  localparam int CUR_W = 17;   // heading remainder in 1/128 degree
  localparam int BRG_W = 18;   // bearing in 1/128 degree

  localparam logic signed [Z_W-1:0] Z_DEG180 = 27'sd11796480;

  localparam int DEG180 = 23040;
  localparam int DEG360 = 46080;

  // heading / 360 by reciprocal: q = (a * 23302) >> 23, exact for a <= 32768
  localparam int HDG_RECIP = 23302;
  localparam int HDG_SHIFT = 23;
  localparam int HDG_MOD   = 360;
  localparam int HDG_Q_W   = 7;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2
  } dir_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN   = 4'd0,
    REG_DERIV_GAIN  = 4'd1,
    REG_DEADBAND    = 4'd2,
    REG_MAX_CONTROL = 4'd3
  } reg_idx_t;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [DB_W-1:0]   deadband;
    logic [MAXC_W-1:0] max_control;
  } regs_t;

  typedef struct packed {
    logic                    valid;
    logic [AMT_W-1:0]        turn_amount;
    dir_t                    turn_dir;
    logic signed [ERR_W-1:0] heading_error;
  } result_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned i);
    case (i)
      0:       return 27'sd2949120;
      1:       return 27'sd1740967;
      2:       return 27'sd919879;
      3:       return 27'sd466945;
      4:       return 27'sd234379;
      5:       return 27'sd117304;
      6:       return 27'sd58666;
      7:       return 27'sd29335;
      8:       return 27'sd14668;
      9:       return 27'sd7334;
      10:      return 27'sd3667;
      11:      return 27'sd1833;
      12:      return 27'sd917;
      13:      return 27'sd458;
      14:      return 27'sd229;
      15:      return 27'sd115;
      16:      return 27'sd57;
      17:      return 27'sd29;
      18:      return 27'sd14;
      19:      return 27'sd7;
      20:      return 27'sd4;
      21:      return 27'sd2;
      22:      return 27'sd1;
      default: return 27'sd0;
    endcase
  endfunction

endpackage

@@ src/hps_if.sv @@
// ============================================================================
// hps_if: channel interfaces of the heading PD steering block
// Item, result and register write channels, valid/ready handshake.
// ============================================================================
interface hps_item_if;
  import hps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic signed [COORD_W-1:0] car_x;
  logic signed [COORD_W-1:0] car_y;
  logic signed [COORD_W-1:0] car_heading;

  modport source (output valid, target_x, target_y, car_x, car_y, car_heading,
                  input ready);
  modport sink (input valid, target_x, target_y, car_x, car_y, car_heading,
                output ready);
endinterface

interface hps_result_if;
  import hps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [AMT_W-1:0]        turn_amount;
  logic [DIR_W-1:0]        turn_dir;
  logic signed [ERR_W-1:0] heading_error;

  modport source (output valid, turn_amount, turn_dir, heading_error, input ready);
  modport sink (input valid, turn_amount, turn_dir, heading_error, output ready);
endinterface

interface hps_cfg_if;
  import hps_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/heading_pd_steer_top.sv @@
// ============================================================================
// heading_pd_steer_top: PD heading controller with angle wrap
// Bearing by CORDIC cell chain, heading mod 360, wrapped error, PD steering.
// ============================================================================
// One word in, one word out. The bearing to the target comes from a chain of
// CORDIC_STEPS vectoring cells, each rotating the vector by one arctangent
// step and passing it to the next cell every cycle. A result passes from the
// last cell through the hps_post stages into the output register, and the
// next item is taken in the cycle after that result has moved into the
// output register; the block takes no new item before that. A result the
// receiver has not yet taken holds the next one back and keeps the input
// stalled. Only one item is at work at a time, since each result updates the
// stored last error that the next item's derivative term needs. Register
// writes are taken at once (ready is always high) and must only come while no
// item is at work.
module heading_pd_steer_top #(
  parameter int CORDIC_STEPS = hps_pkg::CORDIC_STEPS_DEF
) (
  input logic          clk,
  input logic          rst,
  hps_item_if.sink     item,
  hps_result_if.source result,
  hps_cfg_if.sink      cfg
);
  import hps_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  regs_t regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain   <= GAIN_W'(655);
      regs.deriv_gain  <= GAIN_W'(655);
      regs.deadband    <= DB_W'(384);
      regs.max_control <= MAXC_W'(65536);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP_GAIN:   regs.prop_gain   <= cfg.data[GAIN_W-1:0];
        REG_DERIV_GAIN:  regs.deriv_gain  <= cfg.data[GAIN_W-1:0];
        REG_DEADBAND:    regs.deadband    <= cfg.data[DB_W-1:0];
        REG_MAX_CONTROL: regs.max_control <= cfg.data[MAXC_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input handshake: busy from accept until the result is in the out register
  // --------------------------------------------------------------------------
  logic    busy;
  logic    accept;
  logic    load;
  result_t fin;
  logic    out_valid;

  assign item.ready = !busy;
  assign accept     = item.valid && !busy;
  assign load       = fin.valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (load) begin
      busy <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // front stage: difference vector, scale by 256, fold into the right half
  // plane with the angle preset to +/-180 degrees
  // --------------------------------------------------------------------------
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [XY_W-1:0]  x_sc;
  logic signed [XY_W-1:0]  y_sc;
  cordic_t                 front;

  assign dx   = $signed({item.target_x[COORD_W-1], item.target_x})
              - $signed({item.car_x[COORD_W-1], item.car_x});
  assign dy   = $signed({item.target_y[COORD_W-1], item.target_y})
              - $signed({item.car_y[COORD_W-1], item.car_y});
  assign x_sc = XY_W'(dx) <<< 8;
  assign y_sc = XY_W'(dy) <<< 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else begin
      front.valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front.zero <= (dx == '0) && (dy == '0);
      if (dx[COORD_W]) begin
        front.x <= -x_sc;
        front.y <= -y_sc;
        front.z <= dy[COORD_W] ? -Z_DEG180 : Z_DEG180;
      end else begin
        front.x <= x_sc;
        front.y <= y_sc;
        front.z <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // heading mod 360, truncating toward zero; quotient by reciprocal multiply
  // at accept, remainder formed while the CORDIC chain runs
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0]          hd_abs;
  logic [COORD_W+14:0]         hd_prod;
  logic [COORD_W-1:0]          hd_abs_r;
  logic [HDG_Q_W-1:0]          hd_q;
  logic                        hd_neg;
  logic [COORD_W-1:0]          hd_rem;
  logic [COORD_W-1:0]          cur_mag;
  logic signed [CUR_W-1:0]     cur;

  assign hd_abs  = item.car_heading[COORD_W-1] ? COORD_W'(-item.car_heading)
                                               : COORD_W'(item.car_heading);
  assign hd_prod = (COORD_W+15)'(hd_abs) * (COORD_W+15)'(HDG_RECIP);
  assign hd_rem  = hd_abs_r - COORD_W'(hd_q) * COORD_W'(HDG_MOD);
  assign cur_mag = hd_rem << 7;   // remainder < 360, fits after x128

  always_ff @(posedge clk) begin
    if (accept) begin
      hd_abs_r <= hd_abs;
      hd_q     <= HDG_Q_W'(hd_prod >> HDG_SHIFT);
      hd_neg   <= item.car_heading[COORD_W-1];
    end
    cur <= hd_neg ? -$signed({1'b0, cur_mag}) : $signed({1'b0, cur_mag});
  end

  // --------------------------------------------------------------------------
  // CORDIC cell chain
  // --------------------------------------------------------------------------
  cordic_t chain [CORDIC_STEPS+1];

  assign chain[0] = front;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    hps_cell #(
      .STAGE(i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // wrap, PD term, limit and direction
  // --------------------------------------------------------------------------
  hps_post u_post (
    .clk  (clk),
    .rst  (rst),
    .din  (chain[CORDIC_STEPS]),
    .cur  (cur),
    .regs (regs),
    .take (load),
    .fin  (fin)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.turn_amount   <= fin.turn_amount;
      result.turn_dir      <= fin.turn_dir;
      result.heading_error <= fin.heading_error;
    end
  end

  assign result.valid = out_valid;

endmodule

@@ src/hps_cell.sv @@
// ============================================================================
// hps_cell: one CORDIC vectoring cell
// Rotates the held vector toward y = 0 by atan(2^-STAGE), registered output.
// ============================================================================
module hps_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  hps_pkg::cordic_t din,
  output hps_pkg::cordic_t dout
);
  import hps_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = atan_lut(STAGE);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [XY_W-1:0] x_next;
  logic signed [XY_W-1:0] y_next;
  logic signed [Z_W-1:0]  z_next;

  assign xs = din.x >>> STAGE;
  assign ys = din.y >>> STAGE;

  always_comb begin
    if (!din.y[XY_W-1]) begin
      x_next = din.x + ys;
      y_next = din.y - xs;
      z_next = din.z + ANGLE;
    end else begin
      x_next = din.x - ys;
      y_next = din.y + xs;
      z_next = din.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.zero <= din.zero;
    dout.x    <= x_next;
    dout.y    <= y_next;
    dout.z    <= z_next;
  end

endmodule

@@ src/hps_post.sv @@
// ============================================================================
// hps_post: error wrap, PD term and saturation
// Four stages: wrap, multiply, sum/shift, magnitude/limit/direction.
// ============================================================================
module hps_post (
  input  logic                             clk,
  input  logic                             rst,
  input  hps_pkg::cordic_t                 din,
  input  logic signed [hps_pkg::CUR_W-1:0] cur,
  input  hps_pkg::regs_t                   regs,
  input  logic                             take,
  output hps_pkg::result_t                 fin
);
  import hps_pkg::*;

  localparam int DIFF_W = BRG_W + 1;
  localparam int P_W    = GAIN_W + ERR_W + 1;
  localparam int DD_W   = ERR_W + 1;
  localparam int D_W    = GAIN_W + DD_W + 1;
  localparam int SUM_W  = D_W + 1;
  localparam int SH_W   = SUM_W - 7;

  // stage 1: bearing round and wrap
  logic signed [BRG_W-1:0]  bear;
  logic signed [Z_W-1:0]    z_rnd;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] wrapped;
  logic                     v1;
  logic signed [ERR_W-1:0]  err1;
  logic signed [ERR_W-1:0]  last_error;

  assign z_rnd = din.z + Z_W'(256);
  assign bear  = din.zero ? '0 : BRG_W'(z_rnd >>> 9);
  assign diff  = DIFF_W'(bear) - DIFF_W'(cur);

  always_comb begin
    if (diff > DIFF_W'(DEG180)) begin
      wrapped = diff - DIFF_W'(DEG360);
    end else if (diff < -DIFF_W'(DEG180)) begin
      wrapped = diff + DIFF_W'(DEG360);
    end else begin
      wrapped = diff;
    end
  end

  // stage 2: products
  logic                     v2;
  logic signed [P_W-1:0]    p_next;
  logic signed [DD_W-1:0]   dd;
  logic signed [D_W-1:0]    d_next;
  logic signed [P_W-1:0]    p;
  logic signed [D_W-1:0]    d;
  logic signed [ERR_W-1:0]  err2;

  assign p_next = P_W'($signed({1'b0, regs.prop_gain})) * P_W'(err1);
  assign dd     = DD_W'(err1) - DD_W'(last_error);
  assign d_next = D_W'($signed({1'b0, regs.deriv_gain})) * D_W'(dd);

  // stage 3: sum and floor shift
  logic                     v3;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sh;
  logic signed [ERR_W-1:0]  err3;

  assign sum = SUM_W'(p) + SUM_W'(d);

  // stage 4: magnitude, limit, direction
  logic [SH_W-1:0]          mag;
  logic [AMT_W-1:0]         amt;
  dir_t                     dir;
  logic signed [DB_W+1:0]   db_s;

  assign mag  = sh[SH_W-1] ? SH_W'(-sh) : SH_W'(sh);
  assign amt  = (mag > SH_W'(regs.max_control)) ? regs.max_control : AMT_W'(mag);
  assign db_s = $signed({2'b00, regs.deadband});

  always_comb begin
    if ((DB_W+2)'(err3) < -db_s) begin
      dir = DIR_RIGHT;
    end else if ((DB_W+2)'(err3) > db_s) begin
      dir = DIR_LEFT;
    end else begin
      dir = DIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      fin.valid  <= 1'b0;
      last_error <= '0;
    end else begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
      if (v1) begin
        last_error <= err1;
      end
      if (v3) begin
        fin.valid <= 1'b1;
      end else if (take) begin
        fin.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid) begin
      err1 <= ERR_W'(wrapped);
    end
    if (v1) begin
      p    <= p_next;
      d    <= d_next;
      err2 <= err1;
    end
    if (v2) begin
      sh   <= SH_W'(sum >>> 7);
      err3 <= err2;
    end
    if (v3) begin
      fin.turn_amount   <= amt;
      fin.turn_dir      <= dir;
      fin.heading_error <= err3;
    end
  end

endmodule

@@ src/hps_chk.sv @@
// ============================================================================
// hps_chk: port-level checks for the heading PD steering block
// Handshake and result checks, bound to the top level.
// ============================================================================
module hps_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [hps_pkg::ERR_W-1:0] heading_error
);
  import hps_pkg::*;

  // a result word stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // one item at work: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is at work");

  // a fresh result only follows a busy period
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item at work");

  // wrapped error lies within half a turn
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_error <= ERR_W'(DEG180)) && (heading_error >= -ERR_W'(DEG180)))
    else $error("heading error outside half a turn");

endmodule

bind heading_pd_steer_top hps_chk u_hps_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item.valid),
  .in_ready      (item.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .heading_error (result.heading_error)
);
